/* sv/prefix_command_decimal_parser_unit_assert.svh */
// ---------------------------------------------------------------------------
// prefix_command_decimal_parser_unit_assert.svh
// Assertion macros used by the checker file of the command parser.
// ---------------------------------------------------------------------------
`ifndef PREFIX_COMMAND_DECIMAL_PARSER_UNIT_ASSERT_SVH
`define PREFIX_COMMAND_DECIMAL_PARSER_UNIT_ASSERT_SVH

// Property checked only while reset is released.
`define PCDP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("pcdp assertion failed");

// Property checked on every edge, reset included.
`define PCDP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pcdp assertion failed");

`endif

/* sv/pcdp_pkg.sv */
// ---------------------------------------------------------------------------
// pcdp_pkg
// Types and constants of the command prefix and decimal parser.
// ---------------------------------------------------------------------------
package pcdp_pkg;

    localparam int unsigned PREFIX_LEN   = 5;
    localparam int unsigned PREFIX_W     = 8 * PREFIX_LEN;
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned POS_W        = 3;

    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 40'h4D4F564520;  // "MOVE "
    localparam logic [7:0]          ASCII_ZERO   = 8'h30;
    localparam logic [7:0]          ASCII_NINE   = 8'h39;
    localparam logic [POS_W-1:0]    POS_DONE     = 3'd5;

    // One received byte of a command line.
    typedef struct packed {
        logic [7:0] cmd_byte;
        logic       line_end;
    } item_t;

    // Result handed from the line core to the output register.
    typedef struct packed {
        logic               load;
        logic               success;
        logic [VALUE_W-1:0] parsed_value;
    } result_t;

endpackage

/* sv/pcdp_in_stage.sv */
// ---------------------------------------------------------------------------
// pcdp_in_stage
// Input register: holds one received item until the line core consumes it.
// ---------------------------------------------------------------------------
module pcdp_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  pcdp_pkg::item_t s_item,
    input  logic            advance,
    output logic            item_valid,
    output pcdp_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    pcdp_pkg::item_t item_reg;

    // Free when empty or when the held item moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* sv/pcdp_line_core.sv */
// ---------------------------------------------------------------------------
// pcdp_line_core
// Per-line state: prefix compare, digit check and decimal accumulation.
// ---------------------------------------------------------------------------
module pcdp_line_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pcdp_pkg::PREFIX_W-1:0]    cfg_wr_data,
    input  logic                             item_valid,
    input  pcdp_pkg::item_t                  item,
    input  logic                             out_free,
    output logic                             advance,
    output pcdp_pkg::result_t                result
);

    logic [pcdp_pkg::PREFIX_W-1:0] prefix_reg;
    logic [pcdp_pkg::POS_W-1:0]    pos_reg;
    logic [pcdp_pkg::POS_W-1:0]    pos_next;
    logic                          failed_reg;
    logic                          failed_next;
    logic [pcdp_pkg::VALUE_W-1:0]  acc_reg;
    logic [pcdp_pkg::VALUE_W-1:0]  acc_next;
    logic [7:0]                    expect_byte;
    logic [pcdp_pkg::VALUE_W-1:0]  acc_times_ten;
    logic [pcdp_pkg::VALUE_W-1:0]  digit_val;
    logic                          ok;

    // A line-end item needs the output register; other items always move
    assign advance = item_valid && (!item.line_end || out_free);

    // Prefix register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= pcdp_pkg::PREFIX_RESET;
        end else if (cfg_wr_en) begin
            prefix_reg <= cfg_wr_data;
        end
    end

    // Expected prefix byte, first byte in the top bits
    always_comb begin
        case (pos_reg)
            3'd0:    expect_byte = prefix_reg[39:32];
            3'd1:    expect_byte = prefix_reg[31:24];
            3'd2:    expect_byte = prefix_reg[23:16];
            3'd3:    expect_byte = prefix_reg[15:8];
            default: expect_byte = prefix_reg[7:0];
        endcase
    end

    // acc * 10 as (acc << 3) + (acc << 1), wrapping at 32 bits
    assign acc_times_ten = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};
    assign digit_val     = {24'd0, item.cmd_byte - pcdp_pkg::ASCII_ZERO};

    // Next line state for the item in the input register
    always_comb begin
        pos_next    = pos_reg;
        failed_next = failed_reg;
        acc_next    = acc_reg;
        if (pos_reg < pcdp_pkg::POS_DONE) begin
            if (item.cmd_byte != expect_byte) begin
                failed_next = 1'b1;
            end
            pos_next = pos_reg + 3'd1;
        end else if (!failed_reg) begin
            if (item.cmd_byte inside {[pcdp_pkg::ASCII_ZERO:pcdp_pkg::ASCII_NINE]}) begin
                acc_next = acc_times_ten + digit_val;
            end else begin
                failed_next = 1'b1;
            end
        end
    end

    // Result on the last byte
    always_comb begin
        ok                  = !failed_next && (pos_next >= pcdp_pkg::POS_DONE);
        result.load         = advance && item.line_end;
        result.success      = ok;
        result.parsed_value = ok ? acc_next : '0;
    end

    // Line state; cleared after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            failed_reg <= 1'b0;
            acc_reg    <= '0;
        end else if (advance) begin
            if (item.line_end) begin
                pos_reg    <= '0;
                failed_reg <= 1'b0;
                acc_reg    <= '0;
            end else begin
                pos_reg    <= pos_next;
                failed_reg <= failed_next;
                acc_reg    <= acc_next;
            end
        end
    end

endmodule

/* sv/pcdp_out_stage.sv */
// ---------------------------------------------------------------------------
// pcdp_out_stage
// Result register: holds one result until the consumer takes it.
// ---------------------------------------------------------------------------
module pcdp_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pcdp_pkg::result_t               result,
    output logic                            out_free,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_success,
    output logic [pcdp_pkg::VALUE_W-1:0]    m_parsed_value
);

    logic                           valid_reg;
    logic                           valid_next;
    logic                           success_reg;
    logic [pcdp_pkg::VALUE_W-1:0]   value_reg;

    // Free when empty or taken this cycle
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (result.load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (result.load) begin
            success_reg <= result.success;
            value_reg   <= result.parsed_value;
        end
    end

    assign m_valid        = valid_reg;
    assign m_success      = success_reg;
    assign m_parsed_value = value_reg;

endmodule

/* sv/prefix_command_decimal_parser_unit.sv */
// ---------------------------------------------------------------------------
// prefix_command_decimal_parser_unit: command prefix check and decimal parse
// A line's last item goes through the input and result registers to m_valid.
// One item per cycle; a line-end item stalls while the result register is full.
// Reset (aresetn low, synchronous) clears line state; prefix returns to "MOVE ".
// ---------------------------------------------------------------------------
module prefix_command_decimal_parser_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pcdp_pkg::PREFIX_W-1:0]   cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_cmd_byte,
    input  logic                            s_line_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_success,
    output logic [pcdp_pkg::VALUE_W-1:0]    m_parsed_value
);

    pcdp_pkg::item_t   s_item;
    pcdp_pkg::item_t   item;
    pcdp_pkg::result_t result;
    logic              item_valid;
    logic              advance;
    logic              out_free;

    assign s_item.cmd_byte = s_cmd_byte;
    assign s_item.line_end = s_line_end;

    pcdp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pcdp_line_core u_line_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .out_free    (out_free),
        .advance     (advance),
        .result      (result)
    );

    pcdp_out_stage u_out_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .result         (result),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_success      (m_success),
        .m_parsed_value (m_parsed_value)
    );

endmodule

/* sv/pcdp_checker.sv */
// ---------------------------------------------------------------------------
// pcdp_checker
// Port-level checks of the command parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "prefix_command_decimal_parser_unit_assert.svh"

module pcdp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_line_end,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_success,
    input logic [pcdp_pkg::VALUE_W-1:0]    m_parsed_value
);

    // A failed line reports value zero
    `PCDP_ASSERT(a_fail_zero, aclk, aresetn, (m_valid && !m_success) |-> (m_parsed_value == '0))

    // A new result comes from a line-end item taken at the input, through the input and result registers
    `PCDP_ASSERT(a_result_source, aclk, aresetn, $rose(m_valid) |-> $past(s_valid && s_ready && s_line_end, 2))

    // A stalled result holds
    `PCDP_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_success) && $stable(m_parsed_value)))

    // Reset empties the result register
    `PCDP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

bind prefix_command_decimal_parser_unit pcdp_checker u_pcdp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_line_end     (s_line_end),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_success      (m_success),
    .m_parsed_value (m_parsed_value)
);
